### rtl/salru_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the set-associative LRU tag lookup unit.
// No dependencies; every other file of the block refers to this package.
package salru_pkg;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int CNT_W      = 64;
    localparam int OFF_W      = 5;
    localparam int SB_W       = 4;
    localparam int WAYS_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [OFF_W-1:0]  OFFSET_BITS_RST = 5'd2;
    localparam logic [SB_W-1:0]   SET_BITS_RST    = 4'd4;
    localparam logic [WAYS_W-1:0] WAYS_RST        = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS    = 2'd0,
        CFG_SET_INDEX_BITS = 2'd1,
        CFG_WAYS_IN_USE    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic hit;
        logic miss;
    } t_lookup_status;

endpackage

### rtl/salru_req_if.sv
`timescale 1ns / 1ps
// Request channel of the LRU tag lookup unit: one byte address per request.
// Depends on salru_pkg for the address width.
interface salru_req_if;
    logic                           valid;
    logic                           ready;
    logic [salru_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

### rtl/salru_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the LRU tag lookup unit: hit flag and running totals.
// Depends on salru_pkg for the counter width.
interface salru_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [salru_pkg::CNT_W-1:0]    hit_total;
    logic [salru_pkg::CNT_W-1:0]    miss_total;

    modport source (output valid, output hit, output hit_total, output miss_total, input ready);
    modport sink   (input valid, input hit, input hit_total, input miss_total, output ready);
endinterface

### rtl/set_assoc_lru_tag_lookup_unit.sv
`timescale 1ns / 1ps
// Top level of the set-associative tag lookup unit with true LRU replacement.
// Depends on salru_pkg, salru_req_if, salru_rsp_if and salru_row_update.
//
// Each request carries a byte address. The address is split into block
// offset, set index and tag with the configured bit counts, the set's row
// is read from the tag memory, the tag is compared against every active way
// at once, and the reordered row is written back. A hit moves its way to the
// most-recent end of the valid run; a miss fills the first empty way or, in
// a full set, drops way 0, shifts the rest down and appends the new tag.
// Every request produces one response with the hit flag and the 64-bit
// wrapping hit and miss totals that include it. The row is read from memory
// into a register at the clock edge that accepts a request; the compare and
// write-back happen in the lookup stage, which then loads the response
// register that presents the response. One request is accepted every cycle
// while responses are taken; a request to the set that the previous request
// just wrote takes that row from a bypass register. While a finished response
// waits, one more request can still enter the lookup stage; after that the
// request side stalls until the response is taken.
// After reset the unit runs a clearing pass over the valid bits of every
// row before it accepts its first request; configuration writes are
// taken at any time. Configuration should only be changed while no request
// is in flight.
module set_assoc_lru_tag_lookup_unit #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [salru_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [salru_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    salru_req_if.sink                           i_req,
    salru_rsp_if.source                         o_rsp
);

    // Widest set count that fits in the memory, and the derived widths.
    localparam int MAX_SB  = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
    localparam int TAGS_W  = MAX_WAYS * salru_pkg::TAG_W;
    localparam int ROW_W   = TAGS_W + MAX_WAYS;
    localparam int SH_W    = salru_pkg::OFF_W + 1;

    // Configuration registers.
    logic [salru_pkg::OFF_W-1:0]  r_cfg_off;
    logic [salru_pkg::SB_W-1:0]   r_cfg_sb;
    logic [salru_pkg::WAYS_W-1:0] r_cfg_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_off  <= salru_pkg::OFFSET_BITS_RST;
            r_cfg_sb   <= salru_pkg::SET_BITS_RST;
            r_cfg_ways <= salru_pkg::WAYS_RST;
        end else if (i_cfg_we) begin
            case (salru_pkg::t_cfg_idx'(i_cfg_idx))
                salru_pkg::CFG_OFFSET_BITS: begin
                    r_cfg_off <= i_cfg_data[salru_pkg::OFF_W-1:0];
                end
                salru_pkg::CFG_SET_INDEX_BITS: begin
                    r_cfg_sb <= i_cfg_data[salru_pkg::SB_W-1:0];
                end
                salru_pkg::CFG_WAYS_IN_USE: begin
                    r_cfg_ways <= i_cfg_data[salru_pkg::WAYS_W-1:0];
                end
                default: begin
                    // Writes to unknown register indexes are dropped.
                end
            endcase
        end
    end

    // Effective set bits are capped so that the set index stays inside the
    // memory; the capped count also sets where the tag starts.
    logic [salru_pkg::SB_W-1:0]     w_sb;
    logic [WCNT_W-1:0]              w_ways;
    logic [SH_W-1:0]                w_tag_sh;
    logic [salru_pkg::ADDR_W-1:0]   w_set_mask;
    logic [SET_W-1:0]               w_set;
    logic [salru_pkg::TAG_W-1:0]    w_tag;

    always_comb begin
        w_sb = (int'(r_cfg_sb) > MAX_SB) ? salru_pkg::SB_W'(MAX_SB) : r_cfg_sb;
        if (r_cfg_ways == '0) begin
            w_ways = WCNT_W'(1);
        end else if (int'(r_cfg_ways) > MAX_WAYS) begin
            w_ways = WCNT_W'(MAX_WAYS);
        end else begin
            w_ways = WCNT_W'(r_cfg_ways);
        end
        // Shift amounts past 31 leave an all-zero tag, which matches the
        // behavior of a 64-bit shift of a 32-bit address.
        w_tag_sh   = SH_W'(r_cfg_off) + SH_W'(w_sb);
        w_set_mask = ~({salru_pkg::ADDR_W{1'b1}} << w_sb);
        w_set      = SET_W'((i_req.address >> r_cfg_off) & w_set_mask);
        w_tag      = salru_pkg::TAG_W'(i_req.address >> w_tag_sh);
    end

    // Pipeline control. The lookup stage and the response register advance
    // together whenever the response register is empty or being drained. An
    // empty lookup stage can also take a request while a response waits.
    logic r_clr_busy;
    logic [SET_W-1:0] r_clr_idx;
    logic r_s1_valid;
    logic r_out_valid;
    logic w_adv;
    logic w_acc;
    logic w_s1_fire;

    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (w_adv || !r_s1_valid) && !r_clr_busy;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_s1_fire   = r_s1_valid && w_adv;

    // Clearing pass: one row per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + SET_W'(1);
            if (r_clr_idx == SET_W'(MAX_SETS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Stage 1 request registers.
    logic [SET_W-1:0]              r_s1_set;
    logic [salru_pkg::TAG_W-1:0]   r_s1_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv || !r_s1_valid) begin
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_set <= w_set;
            r_s1_tag <= w_tag;
        end
    end

    // Tag memory: one row per set, holding the valid bits above the tags.
    logic [ROW_W-1:0]  r_mem [MAX_SETS];
    logic [ROW_W-1:0]  r_rd_row;
    logic              w_mem_we;
    logic [SET_W-1:0]  w_mem_waddr;
    logic [ROW_W-1:0]  w_mem_wdata;
    logic [ROW_W-1:0]  n_row;

    assign w_mem_we    = r_clr_busy || w_s1_fire;
    assign w_mem_waddr = r_clr_busy ? r_clr_idx : r_s1_set;
    assign w_mem_wdata = r_clr_busy ? '0 : n_row;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_acc) begin
            r_rd_row <= r_mem[w_set];
        end
    end

    // Bypass of the last row written, for a request whose read raced the
    // write of the request ahead of it.
    logic              r_fw_valid;
    logic [SET_W-1:0]  r_fw_set;
    logic [ROW_W-1:0]  r_fw_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else if (w_s1_fire) begin
            r_fw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_fw_set <= r_s1_set;
            r_fw_row <= n_row;
        end
    end

    logic [ROW_W-1:0]                          w_row;
    logic [MAX_WAYS-1:0][salru_pkg::TAG_W-1:0] w_row_tags;
    logic [MAX_WAYS-1:0]                       w_row_valid;
    logic [MAX_WAYS-1:0][salru_pkg::TAG_W-1:0] w_new_tags;
    logic [MAX_WAYS-1:0]                       w_new_valid;
    salru_pkg::t_lookup_status                 w_status;

    assign w_row       = (r_fw_valid && (r_fw_set == r_s1_set)) ? r_fw_row : r_rd_row;
    assign w_row_tags  = w_row[TAGS_W-1:0];
    assign w_row_valid = w_row[ROW_W-1:TAGS_W];
    assign n_row       = {w_new_valid, w_new_tags};

    salru_row_update #(
        .MAX_WAYS (MAX_WAYS)
    ) u_row_update (
        .i_tags   (w_row_tags),
        .i_valid  (w_row_valid),
        .i_tag    (r_s1_tag),
        .i_ways   (w_ways),
        .o_tags   (w_new_tags),
        .o_valid  (w_new_valid),
        .o_status (w_status)
    );

    // Running totals double as the response payload: they only move when a
    // new response is loaded.
    logic [salru_pkg::CNT_W-1:0] r_hit_cnt;
    logic [salru_pkg::CNT_W-1:0] r_miss_cnt;
    logic                        r_out_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                if (w_status.hit) begin
                    r_hit_cnt <= r_hit_cnt + salru_pkg::CNT_W'(1);
                end
                if (w_status.miss) begin
                    r_miss_cnt <= r_miss_cnt + salru_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_out_hit <= w_status.hit;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.hit_total  = r_hit_cnt;
    assign o_rsp.miss_total = r_miss_cnt;

`ifndef SYNTHESIS
    // Every lookup is exactly one of hit or miss.
    a_status_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $onehot({w_status.hit, w_status.miss}))
        else $error("lookup status is not exactly one of hit or miss");

    // Each completed lookup raises the combined totals by exactly one.
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_fire |=> ((r_hit_cnt + r_miss_cnt) == ($past(r_hit_cnt + r_miss_cnt) + 64'd1)))
        else $error("hit and miss totals did not advance by one");

    // Totals stay put while no lookup completes.
    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_fire |=> ($stable(r_hit_cnt) && $stable(r_miss_cnt)))
        else $error("totals changed without a completed lookup");

    // The valid ways of a written row form one run starting at way 0.
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_fire |-> ((w_new_valid & (w_new_valid + MAX_WAYS'(1))) == '0))
        else $error("valid ways of a set are not packed from way 0");
`endif

endmodule

### rtl/salru_row_update.sv
`timescale 1ns / 1ps
// Combinational search and LRU reorder of one cache set (one memory row).
// Depends on salru_pkg for the tag width and the lookup status struct.
module salru_row_update #(
    parameter int MAX_WAYS = 8
) (
    input  logic [MAX_WAYS-1:0][salru_pkg::TAG_W-1:0] i_tags,
    input  logic [MAX_WAYS-1:0]                       i_valid,
    input  logic [salru_pkg::TAG_W-1:0]               i_tag,
    input  logic [$clog2(MAX_WAYS+1)-1:0]             i_ways,
    output logic [MAX_WAYS-1:0][salru_pkg::TAG_W-1:0] o_tags,
    output logic [MAX_WAYS-1:0]                       o_valid,
    output salru_pkg::t_lookup_status                 o_status
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [MAX_WAYS-1:0]                       w_stop;
    logic [MAX_WAYS-1:0]                       w_brk;
    logic [MAX_WAYS-1:0]                       w_vnext;
    logic [MAX_WAYS-1:0][salru_pkg::TAG_W-1:0] w_tnext;
    logic                                      w_found;
    logic                                      w_hit;
    logic                                      w_end_found;
    logic [WAY_W-1:0]                          w_first;
    logic [WAY_W-1:0]                          w_lo;
    logic [WAY_W-1:0]                          w_end;
    logic [salru_pkg::TAG_W-1:0]               w_ins;

    // Neighbor views: entry j sees what sits in way j+1.
    assign w_vnext = i_valid >> 1;
    assign w_tnext = i_tags >> salru_pkg::TAG_W;

    always_comb begin
        w_found = 1'b0;
        w_first = '0;
        for (int j = 0; j < MAX_WAYS; j++) begin
            // A way stops the search when it is empty or holds the tag.
            w_stop[j] = (j < int'(i_ways)) && (!i_valid[j] || (i_tags[j] == i_tag));
            // The valid run starting at a way ends here when the next way is
            // outside the active ways or empty.
            w_brk[j]  = ((j + 1) >= int'(i_ways)) || !w_vnext[j];
        end
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (w_stop[j] && !w_found) begin
                w_found = 1'b1;
                w_first = WAY_W'(j);
            end
        end
        w_hit = w_found && i_valid[w_first];

        // A full-set miss rotates the whole valid run, starting at way 0.
        w_lo = w_found ? w_first : '0;

        w_end_found = 1'b0;
        w_end       = w_lo;
        if (!(w_found && !w_hit)) begin
            for (int j = 0; j < MAX_WAYS; j++) begin
                if ((j >= int'(w_lo)) && w_brk[j] && !w_end_found) begin
                    w_end_found = 1'b1;
                    w_end       = WAY_W'(j);
                end
            end
        end

        w_ins = w_hit ? i_tags[w_first] : i_tag;

        for (int j = 0; j < MAX_WAYS; j++) begin
            if ((j >= int'(w_lo)) && (j < int'(w_end))) begin
                o_tags[j] = w_tnext[j];
            end else if (j == int'(w_end)) begin
                o_tags[j] = w_ins;
            end else begin
                o_tags[j] = i_tags[j];
            end
        end

        o_valid        = i_valid;
        o_valid[w_end] = 1'b1;

        o_status.hit  = w_hit;
        o_status.miss = !w_hit;
    end

endmodule
